// ===== rtl/ips_pkg.sv =====
// ips_pkg: shared types, constants and helper functions of the image parameter stack
// no dependencies; used by ips_core and image_parameter_stack
`default_nettype none

package ips_pkg;

    // stack geometry and coordinate storage width
    localparam int DEPTH      = 4;
    localparam int COORD_BITS = 16;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FIELD_W    = 16;
    localparam int LVL_W      = 2;

    localparam logic [PTR_W-1:0] TP_MAX = PTR_W'(DEPTH - 1);

    // action codes
    typedef enum logic [2:0] {
        ACT_LOAD   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_PUSH   = 3'd2,
        ACT_SWAP   = 3'd3,
        ACT_ORIGIN = 3'd4,
        ACT_SIZE   = 3'd5,
        ACT_READ   = 3'd6
    } t_action;

    // status codes
    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_UNDERFLOW  = 3'd1,
        STS_OVERFLOW   = 3'd2,
        STS_BAD_ORIGIN = 3'd3,
        STS_BAD_SIZE   = 3'd4,
        STS_UNKNOWN    = 3'd5
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SWAP,
        ST_SWAP_WR
    } t_state;

    // one stored record
    typedef struct packed {
        logic [COORD_BITS-1:0] ox;
        logic [COORD_BITS-1:0] oy;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    localparam t_rec REC_RESET = '{
        ox: '0,
        oy: '0,
        sx: COORD_BITS'(1),
        sy: COORD_BITS'(1)
    };

    // input item
    typedef struct packed {
        logic [2:0]                action;
        logic signed [FIELD_W-1:0] origin_x;
        logic signed [FIELD_W-1:0] origin_y;
        logic signed [FIELD_W-1:0] size_x;
        logic signed [FIELD_W-1:0] size_y;
    } t_in_item;

    // result item
    typedef struct packed {
        logic signed [FIELD_W-1:0] top_origin_x;
        logic signed [FIELD_W-1:0] top_origin_y;
        logic signed [FIELD_W-1:0] top_size_x;
        logic signed [FIELD_W-1:0] top_size_y;
        logic [LVL_W-1:0]          top_level;
        logic [2:0]                status;
    } t_out_item;

    // core status toward the handshake logic
    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

    // sign-extend an input field, keep the stored width
    function automatic logic [COORD_BITS-1:0] to_coord(input logic signed [FIELD_W-1:0] v);
        logic [31:0] ext;
        ext = 32'(v);
        return ext[COORD_BITS-1:0];
    endfunction

    // stored coordinate to output field width
    function automatic logic [FIELD_W-1:0] to_out(input logic [COORD_BITS-1:0] c);
        logic [31:0] ext;
        ext = 32'(c);
        return ext[FIELD_W-1:0];
    endfunction

    // stack pointer to output level width
    function automatic logic [LVL_W-1:0] to_lvl(input logic [PTR_W-1:0] p);
        logic [31:0] ext;
        ext = 32'(p);
        return ext[LVL_W-1:0];
    endfunction

    // size check: negative or zero is rejected
    function automatic logic below_one(input logic signed [FIELD_W-1:0] v);
        return v[FIELD_W-1] || (v == '0);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/image_parameter_stack.sv =====
// image_parameter_stack: top level with input handshake and result register
// depends on ips_pkg and ips_core
`default_nettype none

// Stack of image-parameter records (origin x/y, size x/y) with the current
// record on top. Each input item carries one action (load, pop, push
// duplicate, swap, set origin, set size, read) and yields exactly one result
// item with the top record, its level and a status. Records live in a small
// ram with a registered read; the top record is also held in registers.
// Load, push, set origin, set size, read and rejected actions finish in the
// idle state; pop makes one ram read, and swap makes one ram read and two ram
// writes through the single write port. Results wait in an output register,
// and a new item is taken in the cycle that register is emptied. No clearing
// pass is needed after reset: per-entry valid bits make unwritten levels read
// as origin 0,0 and size 1,1.
module image_parameter_stack (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire ips_pkg::t_in_item   i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output ips_pkg::t_out_item       o_out_item
);

    ips_pkg::t_core_stat  stat;
    ips_pkg::t_out_item   res;
    logic                 start;

    logic                 r_out_vld, n_out_vld;
    ips_pkg::t_out_item   r_out_item, n_out_item;

    // action sequencer and record store
    ips_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_item (i_in_item),
        .o_stat (stat),
        .o_res  (res)
    );

    // take an item when idle and the result slot is free or being freed
    assign o_in_ready = stat.idle && (!r_out_vld || i_out_ready);
    assign start      = i_in_valid && o_in_ready;

    // result register next values
    always_comb begin
        n_out_vld  = r_out_vld;
        n_out_item = r_out_item;
        if (stat.done) begin
            n_out_vld  = 1'b1;
            n_out_item = res;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ===== rtl/ips_ram.sv =====
// ips_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module ips_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  wire logic [WIDTH-1:0]              i_wdata,
    input  wire logic                          i_re,
    input  wire logic [$clog2(DEPTH)-1:0]      i_raddr,
    output logic      [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/ips_core.sv =====
// ips_core: action sequencer, cached top record and record ram control
// depends on ips_pkg and ips_ram
`default_nettype none

module ips_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire ips_pkg::t_in_item  i_item,
    output ips_pkg::t_core_stat     o_stat,
    output ips_pkg::t_out_item      o_res
);

    ips_pkg::t_state                  r_state, n_state;
    logic [ips_pkg::PTR_W-1:0]        r_tp, n_tp;
    logic [ips_pkg::PTR_W-1:0]        r_other, n_other;
    ips_pkg::t_rec                    r_top, n_top;
    logic [ips_pkg::DEPTH-1:0]        r_vld;
    logic                             r_rd_vld;

    logic                             we;
    logic [ips_pkg::PTR_W-1:0]        waddr;
    ips_pkg::t_rec                    wdata;
    logic                             re;
    logic [ips_pkg::PTR_W-1:0]        raddr;
    logic [ips_pkg::REC_W-1:0]        rdata;
    ips_pkg::t_rec                    rd_rec;
    logic                             done;
    ips_pkg::t_status                 status;
    logic [ips_pkg::PTR_W-1:0]        other;

    // record store
    ips_ram #(
        .WIDTH(ips_pkg::REC_W),
        .DEPTH(ips_pkg::DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // never-written entries read as the reset record
    assign rd_rec = r_rd_vld ? ips_pkg::t_rec'(rdata) : ips_pkg::REC_RESET;

    // swap partner: level 1 at the bottom, else the level below
    assign other = (r_tp == '0) ? ips_pkg::PTR_W'(1) : r_tp - 1'b1;

    // next state, ram access and result
    always_comb begin
        n_state = r_state;
        n_tp    = r_tp;
        n_top   = r_top;
        n_other = r_other;
        we      = 1'b0;
        waddr   = r_tp;
        wdata   = r_top;
        re      = 1'b0;
        raddr   = r_tp;
        done    = 1'b0;
        status  = ips_pkg::STS_OK;

        unique case (r_state)
            ips_pkg::ST_IDLE: begin
                if (i_start) begin
                    unique case (ips_pkg::t_action'(i_item.action))
                        ips_pkg::ACT_LOAD: begin
                            n_top.ox = ips_pkg::to_coord(i_item.origin_x);
                            n_top.oy = ips_pkg::to_coord(i_item.origin_y);
                            n_top.sx = ips_pkg::to_coord(i_item.size_x);
                            n_top.sy = ips_pkg::to_coord(i_item.size_y);
                            we       = 1'b1;
                            wdata    = n_top;
                            done     = 1'b1;
                        end
                        ips_pkg::ACT_POP: begin
                            if (r_tp == '0) begin
                                status = ips_pkg::STS_UNDERFLOW;
                                done   = 1'b1;
                            end else begin
                                re      = 1'b1;
                                raddr   = r_tp - 1'b1;
                                n_state = ips_pkg::ST_POP;
                            end
                        end
                        ips_pkg::ACT_PUSH: begin
                            if (r_tp == ips_pkg::TP_MAX) begin
                                status = ips_pkg::STS_OVERFLOW;
                            end else begin
                                we    = 1'b1;
                                waddr = r_tp + 1'b1;
                                wdata = r_top;
                                n_tp  = r_tp + 1'b1;
                            end
                            done = 1'b1;
                        end
                        ips_pkg::ACT_SWAP: begin
                            re      = 1'b1;
                            raddr   = other;
                            n_other = other;
                            n_state = ips_pkg::ST_SWAP;
                        end
                        ips_pkg::ACT_ORIGIN: begin
                            if (i_item.origin_x[ips_pkg::FIELD_W-1] ||
                                i_item.origin_y[ips_pkg::FIELD_W-1]) begin
                                status = ips_pkg::STS_BAD_ORIGIN;
                            end else begin
                                n_top.ox = ips_pkg::to_coord(i_item.origin_x);
                                n_top.oy = ips_pkg::to_coord(i_item.origin_y);
                                we       = 1'b1;
                                wdata    = n_top;
                            end
                            done = 1'b1;
                        end
                        ips_pkg::ACT_SIZE: begin
                            if (ips_pkg::below_one(i_item.size_x) ||
                                ips_pkg::below_one(i_item.size_y)) begin
                                status = ips_pkg::STS_BAD_SIZE;
                            end else begin
                                n_top.sx = ips_pkg::to_coord(i_item.size_x);
                                n_top.sy = ips_pkg::to_coord(i_item.size_y);
                                we       = 1'b1;
                                wdata    = n_top;
                            end
                            done = 1'b1;
                        end
                        ips_pkg::ACT_READ: begin
                            done = 1'b1;
                        end
                        default: begin
                            status = ips_pkg::STS_UNKNOWN;
                            done   = 1'b1;
                        end
                    endcase
                end
            end
            ips_pkg::ST_POP: begin
                // level below becomes the new top
                n_top   = rd_rec;
                n_tp    = r_tp - 1'b1;
                done    = 1'b1;
                n_state = ips_pkg::ST_IDLE;
            end
            ips_pkg::ST_SWAP: begin
                // old top goes to the partner slot
                we      = 1'b1;
                waddr   = r_other;
                wdata   = r_top;
                n_top   = rd_rec;
                done    = 1'b1;
                n_state = ips_pkg::ST_SWAP_WR;
            end
            ips_pkg::ST_SWAP_WR: begin
                // partner record goes to the top slot
                we      = 1'b1;
                waddr   = r_tp;
                wdata   = r_top;
                n_state = ips_pkg::ST_IDLE;
            end
            default: begin
                n_state = ips_pkg::ST_IDLE;
            end
        endcase
    end

    // control state and cached top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ips_pkg::ST_IDLE;
            r_tp     <= '0;
            r_top    <= ips_pkg::REC_RESET;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_other  <= '0;
        end else begin
            r_state <= n_state;
            r_tp    <= n_tp;
            r_top   <= n_top;
            r_other <= n_other;
            if (we) begin
                r_vld[waddr] <= 1'b1;
            end
            if (re) begin
                r_rd_vld <= r_vld[raddr];
            end
        end
    end

    // status and result toward the output register
    assign o_stat.idle = (r_state == ips_pkg::ST_IDLE);
    assign o_stat.done = done;

    assign o_res.top_origin_x = ips_pkg::to_out(n_top.ox);
    assign o_res.top_origin_y = ips_pkg::to_out(n_top.oy);
    assign o_res.top_size_x   = ips_pkg::to_out(n_top.sx);
    assign o_res.top_size_y   = ips_pkg::to_out(n_top.sy);
    assign o_res.top_level    = ips_pkg::to_lvl(n_tp);
    assign o_res.status       = status;

    // an item starts only while the sequencer is idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == ips_pkg::ST_IDLE)
        else $error("item started while sequencer busy");

    // the pointer moves by at most one level per cycle
    a_tp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_tp != $past(r_tp)) |->
        (r_tp == ips_pkg::PTR_W'($past(r_tp) + 1'b1) ||
         r_tp == ips_pkg::PTR_W'($past(r_tp) - 1'b1)))
        else $error("stack pointer jumped");

    // no ram write while a pop read is returning
    a_pop_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ips_pkg::ST_POP |-> !we)
        else $error("ram write during pop");

    // swap always finishes with the second write-back
    a_swap_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ips_pkg::ST_SWAP |=> (r_state == ips_pkg::ST_SWAP_WR && we))
        else $error("swap write-back missing");

endmodule

`default_nettype wire
